// ----- rtl/core/pps_pkg.sv -----
// shared types and constants of the preemptive priority scheduler
`timescale 1ns / 1ps

package pps_pkg;

    // configuration register
    localparam int          ACTIVE_W     = 5;
    localparam logic [4:0]  ACTIVE_RESET = 5'd16;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // saturating count of unfinished slots seen in a scan
    localparam logic [1:0] UNFIN_NONE = 2'd0;
    localparam logic [1:0] UNFIN_ONE  = 2'd1;
    localparam logic [1:0] UNFIN_MANY = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } t_in_item;

    typedef struct packed {
        logic        idle;
        logic [3:0]  running_slot;
        logic        finished;
        logic [23:0] comp_time;
        logic [23:0] turnaround;
        logic [23:0] waiting;
        logic        all_done;
    } t_out_item;

    // one word of the task table
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] remaining;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // control from the sequencer to the selector
    typedef struct packed {
        logic clear;
        logic eval;
    } t_sel_ctl;

    // selector status
    typedef struct packed {
        logic       found;
        logic [1:0] unfin;
    } t_sel_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_UPD,
        S_DIFF,
        S_FIN
    } t_state;

endpackage

// ----- rtl/core/pps_if.sv -----
// valid/ready channel interfaces for task items and result items
`timescale 1ns / 1ps

interface pps_in_if
    import pps_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pps_out_if
    import pps_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/pps_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pps_select.sv -----
// running winner selection over the entries streamed out of the task table
`timescale 1ns / 1ps

module pps_select
    import pps_pkg::*;
#(
    parameter int IDX_W     = 4,
    parameter int TIME_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sel_ctl             i_ctl,
    input  logic [IDX_W-1:0]     i_idx,
    input  t_entry               i_entry,
    input  logic                 i_live,
    input  logic [TIME_BITS-1:0] i_time,
    output t_sel_stat            o_stat,
    output logic [IDX_W-1:0]     o_slot,
    output t_entry               o_entry
);

    logic             r_found;
    logic [1:0]       r_unfin;
    logic [IDX_W-1:0] r_slot;
    t_entry           r_entry;

    logic [15:0] rem;
    logic        pending;
    logic        eligible;
    logic        better;

    always_comb begin
        rem      = i_live ? i_entry.remaining : 16'd0;
        pending  = (rem != 16'd0);
        eligible = pending && (TIME_BITS'(i_entry.arrival) <= i_time);
        // lower prio number wins, then earlier arrival, then the lower slot
        better   = !r_found
                || (i_entry.prio < r_entry.prio)
                || ((i_entry.prio == r_entry.prio) && (i_entry.arrival < r_entry.arrival));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_unfin <= UNFIN_NONE;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
            r_unfin <= UNFIN_NONE;
        end else if (i_ctl.eval) begin
            if (pending && (r_unfin != UNFIN_MANY)) begin
                r_unfin <= r_unfin + 2'd1;
            end
            if (eligible && better) begin
                r_found <= 1'b1;
            end
        end
    end

    // an eligible entry is always a loaded one, so its stored remaining time holds
    always_ff @(posedge i_clk) begin
        if (i_ctl.eval && eligible && better) begin
            r_slot  <= i_idx;
            r_entry <= i_entry;
        end
    end

    assign o_stat.found = r_found;
    assign o_stat.unfin = r_unfin;
    assign o_slot       = r_slot;
    assign o_entry      = r_entry;

endmodule

// ----- rtl/core/preemptive_priority_scheduler.sv -----
// top level of the preemptive priority scheduler
`timescale 1ns / 1ps

// The task table (arrival, burst, priority, remaining) lives in one ram with a
// single read port. A load transaction writes one slot and sets its remaining
// time to the burst; a tick transaction scans slots 0 .. n-1 (n = active_count
// clamped to MAX_TASKS), one slot per cycle, picks the arrived unfinished task
// with the lowest priority number (ties to the earlier arrival, then the
// lower slot), runs it for one time unit and writes its remaining time back.
// Every transaction gives exactly one result transaction. A tick goes through
// the states scan, update, diff and fin; a load through load, scan and fin.
// The result is registered on leaving fin. A new transaction is taken as
// soon as the previous result sits in the output register, even while that
// result waits for the sink. Slots never loaded since reset count as empty;
// the time counter saturates at all ones and time values are reported in
// their low 24 bits. active_count is to be written only while the block is
// idle; the block itself does not enforce this.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pps_in_if.sink              i_task,
    pps_out_if.source           o_res,
    input  logic                i_cfg_we,
    input  logic [ACTIVE_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int LIM_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // control registers
    t_state                r_state, n_state;
    logic [ACTIVE_W-1:0]   r_active;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [MAX_TASKS-1:0]  r_live;
    logic [TIME_BITS-1:0]  r_time, n_time;
    logic                  r_out_valid;

    // payload registers
    t_in_item              r_item;
    logic [CNT_W-1:0]      r_limit;
    logic [IDX_W-1:0]      r_eval_idx;
    logic                  r_fin, n_fin;
    logic [TIME_BITS-1:0]  r_tat, n_tat;
    t_out_item             r_out;

    // handshakes
    logic in_fire;
    logic take_out;

    // table access
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                ram_wdata;
    logic                  rd_en;
    t_entry                rd_entry;
    logic                  load_we;

    // selector
    t_sel_ctl              sel_ctl;
    t_sel_stat             sel_stat;
    logic [IDX_W-1:0]      best_slot;
    t_entry                best_entry;

    // helpers
    logic [IDX_W+3:0]      slot_ext;
    logic [IDX_W-1:0]      slot_addr;
    logic                  slot_ok;
    logic [IDX_W+3:0]      best_ext;
    t_entry                load_entry;
    t_entry                upd_entry;
    logic [LIM_W-1:0]      act_ext;
    logic [LIM_W-1:0]      max_ext;
    logic [LIM_W-1:0]      lim_sel;
    logic [TIME_BITS-1:0]  burst_ext;
    logic [TIME_BITS-1:0]  wait_full;
    logic [TIME_BITS+23:0] comp_ext;
    logic [TIME_BITS+23:0] tat_ext;
    logic [TIME_BITS+23:0] wait_ext;
    t_out_item             res;

    assign in_fire      = i_task.valid && i_task.ready;
    assign i_task.ready = (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    // load slot decode, out-of-range slots are dropped
    assign slot_ext  = (IDX_W + 4)'(r_item.slot);
    assign slot_addr = slot_ext[IDX_W-1:0];
    assign slot_ok   = (32'(r_item.slot) < MAX_TASKS);
    assign best_ext  = (IDX_W + 4)'(best_slot);

    // active slot count clamped to the table depth
    assign act_ext = LIM_W'(r_active);
    assign max_ext = LIM_W'(MAX_TASKS);
    assign lim_sel = (act_ext > max_ext) ? max_ext : act_ext;

    always_comb begin
        load_entry.arrival   = r_item.arrival;
        load_entry.burst     = r_item.burst;
        load_entry.prio      = r_item.prio;
        load_entry.remaining = r_item.burst;
        upd_entry            = best_entry;
        upd_entry.remaining  = best_entry.remaining - 16'd1;
    end

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    pps_select #(
        .IDX_W     (IDX_W),
        .TIME_BITS (TIME_BITS)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_idx   (r_eval_idx),
        .i_entry (rd_entry),
        .i_live  (r_live[r_eval_idx]),
        .i_time  (r_time),
        .o_stat  (sel_stat),
        .o_slot  (best_slot),
        .o_entry (best_entry)
    );

    // sequencer: next state and table control
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_time    = r_time;
        n_fin     = r_fin;
        n_tat     = r_tat;
        sel_ctl   = '0;
        ram_we    = 1'b0;
        ram_waddr = slot_addr;
        ram_wdata = load_entry;
        rd_en     = 1'b0;
        load_we   = 1'b0;
        take_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    sel_ctl.clear = 1'b1;
                    n_idx         = '0;
                    n_state       = (i_task.data.kind == KIND_LOAD) ? S_LOAD : S_SCAN;
                end
            end
            S_LOAD: begin
                // write before the scan so all_done sees the new entry
                load_we = slot_ok;
                ram_we  = slot_ok;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // read issue and evaluation overlap; each slot is evaluated in the cycle after its read
                rd_en        = (r_idx < r_limit);
                sel_ctl.eval = r_pend;
                n_pend       = rd_en;
                if (rd_en) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (!rd_en && !r_pend) begin
                    n_state = (r_item.kind == KIND_LOAD) ? S_FIN : S_UPD;
                end
            end
            S_UPD: begin
                n_time = (r_time == TIME_MAX) ? r_time : r_time + TIME_BITS'(1);
                if (sel_stat.found) begin
                    ram_we    = 1'b1;
                    ram_waddr = best_slot;
                    ram_wdata = upd_entry;
                end
                n_fin   = sel_stat.found && (best_entry.remaining == 16'd1);
                n_state = S_DIFF;
            end
            S_DIFF: begin
                // time is already advanced and, when a winner was found, never below its arrival here
                n_tat   = r_time - TIME_BITS'(best_entry.arrival);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    take_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result assembly
    always_comb begin
        burst_ext = TIME_BITS'(best_entry.burst);
        wait_full = (r_tat >= burst_ext) ? r_tat - burst_ext : '0;
        comp_ext  = (TIME_BITS + 24)'(r_time);
        tat_ext   = (TIME_BITS + 24)'(r_tat);
        wait_ext  = (TIME_BITS + 24)'(wait_full);
        res       = '0;
        res.idle  = 1'b1;
        if (r_item.kind == KIND_TICK) begin
            res.idle     = !sel_stat.found;
            res.all_done = (sel_stat.unfin == UNFIN_NONE)
                        || ((sel_stat.unfin == UNFIN_ONE) && r_fin);
            if (sel_stat.found) begin
                res.running_slot = best_ext[3:0];
            end
            if (r_fin) begin
                res.finished   = 1'b1;
                res.comp_time  = comp_ext[23:0];
                res.turnaround = tat_ext[23:0];
                res.waiting    = wait_ext[23:0];
            end
        end else begin
            res.all_done = (sel_stat.unfin == UNFIN_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RESET;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_live      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_time  <= n_time;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (load_we) begin
                r_live[slot_addr] <= 1'b1;
            end
            if (take_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_idx[IDX_W-1:0];
        r_fin      <= n_fin;
        r_tat      <= n_tat;
        if (in_fire) begin
            r_item  <= i_task.data;
            r_limit <= lim_sel[CNT_W-1:0];
        end
        if (take_out) begin
            r_out <= res;
        end
    end

    // time only moves forward
    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_time >= $past(r_time)))
        else $error("time counter went backwards");

    // the table is written only by a load or by the winner update
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_LOAD) || (r_state == S_UPD)))
        else $error("table written outside load or update");

    // no read of the table while it is being written
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !rd_en)
        else $error("table read and write in the same cycle");

    // a completion always comes with a running task
    a_finish_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.finished) |-> !o_res.data.idle)
        else $error("finished result marked idle");

endmodule

// ----- verif/tb_preemptive_priority_scheduler.sv -----
// testbench for the preemptive priority scheduler: directed table plus random task sets
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;
    import pps_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int N_SLOTS         = 16;
    // settle time after the last result, covering a full tick with margin
    localparam int DRAIN_CYCLES    = N_SLOTS + 10;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int PHASES          = 6;
    localparam int DIR_ROWS        = 18;
    // watchdog limit, well above the longest correct stretch without a transaction
    localparam int WATCHDOG_LIMIT  = 1000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [ACTIVE_W-1:0] i_cfg_wdata;

    pps_in_if  task_if ();
    pps_out_if res_if ();

    preemptive_priority_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_task      (task_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow copy of the task table and scheduler state
    logic [15:0]         arr_tab   [N_SLOTS];
    logic [15:0]         burst_tab [N_SLOTS];
    logic [7:0]          prio_tab  [N_SLOTS];
    logic [15:0]         rem_tab   [N_SLOTS];
    logic [23:0]         now_t;
    logic [ACTIVE_W-1:0] active_reg;

    // results still owed by the block, oldest first
    t_out_item sched_results_q [$];

    bit done_flag;     // all_done of the latest predicted result
    bit calm;          // when set, neither side idles
    int fail_count;
    int items_sent;
    int quiet_cycles;

    // one row of the directed table; exp_* only matter when typed is set,
    // and then every other result field is expected to be zero
    typedef struct {
        logic        kind;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        bit          typed;
        logic        exp_idle;
        logic        exp_all_done;
    } t_dir_row;

    t_dir_row dir_rows [DIR_ROWS];

    // idle length: mostly short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // next scheduler decision for one accepted transaction
    function automatic t_out_item predict_schedule(input t_in_item it);
        t_out_item   r;
        int          lim;
        int          best;
        bit          found;
        logic [23:0] span_t;
        logic [23:0] burst_t;
        r      = '0;
        r.idle = 1'b1;
        lim    = (active_reg > N_SLOTS) ? N_SLOTS : int'(active_reg);
        if (it.kind == KIND_LOAD) begin
            arr_tab[it.slot]   = it.arrival;
            burst_tab[it.slot] = it.burst;
            prio_tab[it.slot]  = it.prio;
            rem_tab[it.slot]   = it.burst;
        end else begin
            found = 1'b0;
            best  = 0;
            // lowest priority number wins, then earliest arrival, then lowest slot
            for (int i = 0; i < lim; i++) begin
                if (rem_tab[i] != 16'd0 && {8'd0, arr_tab[i]} <= now_t) begin
                    if (!found || prio_tab[i] < prio_tab[best] ||
                        (prio_tab[i] == prio_tab[best] && arr_tab[i] < arr_tab[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            // time saturates at all ones
            if (now_t != '1) now_t = now_t + 24'd1;
            if (found) begin
                r.idle         = 1'b0;
                r.running_slot = 4'(best);
                rem_tab[best]  = rem_tab[best] - 16'd1;
                if (rem_tab[best] == 16'd0) begin
                    span_t       = now_t - {8'd0, arr_tab[best]};
                    burst_t      = {8'd0, burst_tab[best]};
                    r.finished   = 1'b1;
                    r.comp_time  = now_t;
                    r.turnaround = span_t;
                    // only goes negative once time has saturated
                    r.waiting    = (span_t >= burst_t) ? span_t - burst_t : '0;
                end
            end
        end
        r.all_done = 1'b1;
        for (int i = 0; i < lim; i++) begin
            if (rem_tab[i] != 16'd0) r.all_done = 1'b0;
        end
        return r;
    endfunction

    // offer one transaction, wait for acceptance, then record what it should produce
    task automatic put_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        int        g;
        t_out_item pred;
        g = calm ? 0 : (($urandom_range(0, 1) == 0) ? 0 : gap_len());
        if (g > 0) begin
            task_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        task_if.valid <= 1'b1;
        task_if.data  <= it;
        @(posedge i_clk);
        while (!task_if.ready) @(posedge i_clk);
        pred      = predict_schedule(it);
        done_flag = pred.all_done;
        sched_results_q.insert(sched_results_q.size(), typed ? typed_res : pred);
        items_sent++;
    endtask

    // stop offering and let every owed result come out, then let the block settle
    task automatic drain();
        task_if.valid <= 1'b0;
        while (sched_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_active(input logic [ACTIVE_W-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        active_reg   = val;
    endtask

    // a task load aimed mostly at the active slots, with near-term arrival
    function automatic t_in_item make_task(input int span);
        t_in_item it;
        int       base;
        it      = '0;
        it.kind = KIND_LOAD;
        it.slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, N_SLOTS - 1))
                                              : 4'($urandom_range(0, span - 1));
        base = int'(now_t);
        if ($urandom_range(0, 24) == 0)
            it.arrival = 16'($urandom);
        else if (base > 8 && $urandom_range(0, 1) == 0)
            it.arrival = 16'(base - $urandom_range(0, 8));
        else
            it.arrival = 16'(base + $urandom_range(0, 4));
        it.burst = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(1, 65535))
                                                : 16'($urandom_range(1, 6));
        // narrow priority range half the time so ties are common
        it.prio  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        return it;
    endfunction

    // one task set: load a few tasks, tick until they all finish or the tick cap is
    // reached, with late arrivals that may preempt and some stray loads mixed in
    task automatic run_episode(input int n);
        t_in_item it;
        int       span;
        int       k;
        int       ticks;
        span  = (n == 0) ? N_SLOTS : n;
        calm  = ($urandom_range(0, 4) == 0);
        k     = ($urandom_range(0, 5) == 0) ? span : $urandom_range(1, (span > 6) ? 6 : span);
        repeat (k) put_item(make_task(span), 1'b0, '0);
        ticks = 0;
        while ((ticks < 2 || !done_flag) && ticks < 60) begin
            if ($urandom_range(0, 9) == 0) begin
                put_item(make_task(span), 1'b0, '0);
            end else if ($urandom_range(0, 29) == 0) begin
                it         = '0;
                it.kind    = KIND_LOAD;
                it.slot    = 4'($urandom);
                it.arrival = 16'($urandom);
                it.burst   = 16'($urandom_range(1, 65535));
                it.prio    = 8'($urandom);
                put_item(it, 1'b0, '0);
            end else begin
                // load fields of a tick are don't care, so randomize them
                it      = t_in_item'({$urandom, $urandom});
                it.kind = KIND_TICK;
                put_item(it, 1'b0, '0);
                ticks++;
            end
        end
        // replace tasks that would hog the table or never arrive
        for (int i = 0; i < n; i++) begin
            if (rem_tab[i] != 16'd0 &&
                (rem_tab[i] > 16'd16 || {8'd0, arr_tab[i]} > now_t + 24'd16)) begin
                it         = '0;
                it.kind    = KIND_LOAD;
                it.slot    = 4'(i);
                it.burst   = 16'd1;
                it.prio    = 8'($urandom);
                put_item(it, 1'b0, '0);
            end
        end
        // now and then hold the sender until every result is back
        if ($urandom_range(0, 24) == 0) drain();
    endtask

    // result side: random stalls and in-order comparison
    always @(posedge i_clk) begin : res_sink
        t_out_item want;
        int        stall_left;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (sched_results_q.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    fail_count++;
                end else begin
                    want = sched_results_q.pop_front();
                    if (res_if.data.idle !== want.idle) begin
                        $error("idle: expected %0d, got %0d", want.idle, res_if.data.idle);
                        fail_count++;
                    end
                    if (res_if.data.running_slot !== want.running_slot) begin
                        $error("running_slot: expected %0d, got %0d",
                               want.running_slot, res_if.data.running_slot);
                        fail_count++;
                    end
                    if (res_if.data.finished !== want.finished) begin
                        $error("finished: expected %0d, got %0d",
                               want.finished, res_if.data.finished);
                        fail_count++;
                    end
                    if (res_if.data.comp_time !== want.comp_time) begin
                        $error("comp_time: expected %0d, got %0d",
                               want.comp_time, res_if.data.comp_time);
                        fail_count++;
                    end
                    if (res_if.data.turnaround !== want.turnaround) begin
                        $error("turnaround: expected %0d, got %0d",
                               want.turnaround, res_if.data.turnaround);
                        fail_count++;
                    end
                    if (res_if.data.waiting !== want.waiting) begin
                        $error("waiting: expected %0d, got %0d",
                               want.waiting, res_if.data.waiting);
                        fail_count++;
                    end
                    if (res_if.data.all_done !== want.all_done) begin
                        $error("all_done: expected %0d, got %0d",
                               want.all_done, res_if.data.all_done);
                        fail_count++;
                    end
                end
            end
            if (calm) begin
                res_if.ready <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = gap_len() - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((task_if.valid && task_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_preemptive_priority_scheduler failed");
                $finish;
            end
        end
    end

    initial begin
        t_in_item            it;
        t_out_item           fixed;
        logic [ACTIVE_W-1:0] cfg;
        int                  eff;
        int                  target;

        // every input known from time zero, reset held low
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        task_if.valid = 1'b0;
        task_if.data  = '0;
        res_if.ready  = 1'b0;
        fail_count    = 0;
        items_sent    = 0;
        quiet_cycles  = 0;
        calm          = 1'b0;
        done_flag     = 1'b1;
        now_t         = '0;
        active_reg    = ACTIVE_RESET;
        for (int i = 0; i < N_SLOTS; i++) begin
            arr_tab[i]   = '0;
            burst_tab[i] = '0;
            prio_tab[i]  = '0;
            rem_tab[i]   = '0;
        end

        // directed sequence: kind, slot, arrival, burst, prio, typed, idle, all_done
        dir_rows = '{
            // tick on an empty table
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b1, 1'b1, 1'b1},
            // all-ones fields, arrival never reached
            '{KIND_LOAD, 4'd15, 16'hffff,  16'hffff,  8'd0,   1'b1, 1'b1, 1'b0},
            // task present but not arrived yet, so the tick is idle
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b1, 1'b1, 1'b0},
            // zero burst: slot counts as finished
            '{KIND_LOAD, 4'd15, 16'd0,     16'd0,     8'd0,   1'b1, 1'b1, 1'b1},
            '{KIND_LOAD, 4'd0,  16'd0,     16'd3,     8'hff,  1'b1, 1'b1, 1'b0},
            '{KIND_LOAD, 4'd1,  16'd3,     16'd2,     8'd0,   1'b1, 1'b1, 1'b0},
            // slot 0 runs alone, then slot 1 arrives and preempts it
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
            // equal priority, later arrival loses
            '{KIND_LOAD, 4'd2,  16'd4,     16'd1,     8'd0,   1'b1, 1'b1, 1'b0},
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
            // equal priority, earlier arrival in a higher slot wins
            '{KIND_LOAD, 4'd3,  16'd0,     16'd1,     8'd0,   1'b1, 1'b1, 1'b0},
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
            // equal priority and arrival: lower slot wins
            '{KIND_LOAD, 4'd4,  16'd4,     16'd1,     8'd0,   1'b1, 1'b1, 1'b0},
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
            // lowest priority task finishes last
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
            // table empty again
            '{KIND_TICK, 4'd0,  16'd0,     16'd0,     8'd0,   1'b1, 1'b1, 1'b1}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with the reset value of active_count
        for (int r = 0; r < DIR_ROWS; r++) begin
            it.kind           = dir_rows[r].kind;
            it.slot           = dir_rows[r].slot;
            it.arrival        = dir_rows[r].arrival;
            it.burst          = dir_rows[r].burst;
            it.prio           = dir_rows[r].prio;
            fixed             = '0;
            fixed.idle        = dir_rows[r].exp_idle;
            fixed.all_done    = dir_rows[r].exp_all_done;
            put_item(it, dir_rows[r].typed, fixed);
        end

        // random part: one register setting per phase, extremes and out-of-range
        // values included (0 disables every slot, above 16 acts as 16)
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: cfg = 5'd1;
                1: cfg = 5'd0;
                2: cfg = 5'd31;
                3: cfg = 5'd7;
                4: cfg = 5'd16;
                default: cfg = 5'($urandom_range(2, 15));
            endcase
            write_active(cfg);
            eff    = (cfg > N_SLOTS) ? N_SLOTS : int'(cfg);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) run_episode(eff);
        end

        calm = 1'b0;
        drain();
        if (fail_count == 0)
            $display("tb_preemptive_priority_scheduler passed");
        else
            $display("tb_preemptive_priority_scheduler failed");
        $finish;
    end

endmodule
